FILE: rtl/sql_query_tokenizer_top_macros.svh
// Assertion helpers shared by the tokenizer modules.
`ifndef SQL_QUERY_TOKENIZER_TOP_MACROS_SVH
`define SQL_QUERY_TOKENIZER_TOP_MACROS_SVH

`ifndef SYNTHESIS

// ante true in a cycle requires cons in the same cycle
`define SQT_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// ante true in a cycle requires cons in the next cycle
`define SQT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SQT_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define SQT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

FILE: rtl/sqt_pkg.sv
package sqt_pkg;

    localparam int POSITION_BITS_DEF = 16;
    localparam int KW_COUNT          = 20;
    localparam int JOB_FIFO_DEPTH    = 4;

    typedef enum logic [1:0] {
        KIND_KEYWORD  = 2'd0,
        KIND_VALUE    = 2'd1,
        KIND_IDENT    = 2'd2,
        KIND_OPERATOR = 2'd3
    } tok_kind_t;

    typedef enum logic [1:0] {
        OP_LPAREN = 2'd0,
        OP_EQUALS = 2'd1,
        OP_COMMA  = 2'd2,
        OP_RPAREN = 2'd3
    } op_code_t;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_EQUALS = 8'h3D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_QUOTE  = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_GAP  = 8'h20;

    // keywords, right-justified, first character in the highest used byte
    localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
        64'("select"), 64'("from"),   64'("where"),   64'("join"),
        64'("on"),     64'("table"),  64'("create"),  64'("delete"),
        64'("insert"), 64'("into"),   64'("update"),  64'("drop"),
        64'("varchar"), 64'("int"),   64'("char"),    64'("str"),
        64'("set"),    64'("drop"),   64'("table"),   64'("fields")
    };

    localparam logic [2:0] KW_LEN [KW_COUNT] = '{
        3'd6, 3'd4, 3'd5, 3'd4, 3'd2, 3'd5, 3'd6, 3'd6, 3'd6, 3'd4,
        3'd6, 3'd4, 3'd7, 3'd3, 3'd4, 3'd3, 3'd3, 3'd4, 3'd5, 3'd6
    };

    // character i of keyword k; zero past the end of the word
    function automatic logic [7:0] kw_byte(input int k, input logic [2:0] i);
        int sh;
        sh = (int'(KW_LEN[k]) - 1 - int'(i)) * 8;
        if (i >= KW_LEN[k]) begin
            return 8'h00;
        end
        return KW_TEXT[k][sh +: 8];
    endfunction

    // one queue entry: everything a character causes, up to two descriptors
    typedef struct packed {
        logic                has_run;
        logic                run_quoted;
        logic [KW_COUNT-1:0] run_hit;
        logic                run_digits;
        logic [15:0]         run_start;
        logic [15:0]         run_len;
        logic                has_op;
        op_code_t            op_code;
        logic [15:0]         op_pos;
    } tok_job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

endpackage

FILE: rtl/sqt_front.sv
`include "sql_query_tokenizer_top_macros.svh"

module sqt_front #(
    parameter int POSITION_BITS = sqt_pkg::POSITION_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_ch,
    input  logic                 s_is_end,
    input  sqt_pkg::fifo_status_t fifo_status,
    output logic                 job_push,
    output sqt_pkg::tok_job_t    job
);
    import sqt_pkg::*;

    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_PLAIN = 2'd1,
        MODE_QUOTE = 2'd2
    } mode_t;

    function automatic logic [POSITION_BITS-1:0] sat_inc(
        input logic [POSITION_BITS-1:0] v
    );
        return (v == POS_MAX) ? v : v + POSITION_BITS'(1);
    endfunction

    mode_t                      mode_reg, mode_next;
    logic                       bslash_reg, bslash_next;
    logic [POSITION_BITS-1:0]   pos_reg, pos_next;
    logic [POSITION_BITS-1:0]   start_reg, start_next;
    logic [POSITION_BITS-1:0]   len_reg, len_next;
    logic [KW_COUNT-1:0]        alive_reg, alive_next;
    logic                       digits_reg, digits_next;

    logic                       accept;
    logic [7:0]                 lc;
    logic                       is_sp, is_op, is_quote, is_bslash, is_digit;
    op_code_t                   opc;
    logic [POSITION_BITS-1:0]   base_len, fed_len, qlen;
    logic [KW_COUNT-1:0]        base_alive, fed_alive, match;
    logic                       base_digits, fed_digits;
    logic [KW_COUNT-1:0]        hit_fed, hit_cur;

    assign s_ready = !fifo_status.full;
    assign accept  = s_valid && s_ready;

    // character classes
    always_comb begin
        lc        = (s_ch >= CH_UPPER_A && s_ch <= CH_UPPER_Z) ? s_ch + CASE_GAP : s_ch;
        is_sp     = s_ch inside {CH_TAB, CH_SPACE, CH_LF, CH_CR};
        is_digit  = s_ch inside {[CH_ZERO:CH_NINE]};
        is_quote  = (s_ch == CH_QUOTE);
        is_bslash = (s_ch == CH_BSLASH);
        is_op     = 1'b1;
        case (s_ch)
            CH_LPAREN: opc = OP_LPAREN;
            CH_EQUALS: opc = OP_EQUALS;
            CH_COMMA:  opc = OP_COMMA;
            CH_RPAREN: opc = OP_RPAREN;
            default: begin
                opc   = OP_LPAREN;
                is_op = 1'b0;
            end
        endcase
    end

    // keyword mask update, all entries in parallel
    always_comb begin
        if (mode_reg == MODE_PLAIN) begin
            base_len    = len_reg;
            base_alive  = alive_reg;
            base_digits = digits_reg;
        end else begin
            base_len    = '0;
            base_alive  = '1;
            base_digits = 1'b1;
        end
        for (int k = 0; k < KW_COUNT; k++) begin
            match[k] = (base_len < POSITION_BITS'(KW_LEN[k]))
                    && (lc == kw_byte(k, base_len[2:0]));
        end
        fed_alive  = base_alive & match;
        fed_len    = sat_inc(base_len);
        fed_digits = base_digits && is_digit;
        qlen       = sat_inc(len_reg);
        for (int k = 0; k < KW_COUNT; k++) begin
            hit_fed[k] = fed_alive[k] && (fed_len == POSITION_BITS'(KW_LEN[k]));
            hit_cur[k] = alive_reg[k] && (len_reg == POSITION_BITS'(KW_LEN[k]));
        end
    end

    always_comb begin
        mode_next   = mode_reg;
        bslash_next = bslash_reg;
        pos_next    = pos_reg;
        start_next  = start_reg;
        len_next    = len_reg;
        alive_next  = alive_reg;
        digits_next = digits_reg;
        job         = '0;
        job.op_code = opc;
        job.op_pos  = 16'(pos_reg);

        if (accept) begin
            pos_next = sat_inc(pos_reg);
            case (mode_reg)
                MODE_PLAIN: begin
                    if (is_sp || is_op) begin
                        job.has_run    = 1'b1;
                        job.run_hit    = hit_cur;
                        job.run_digits = digits_reg;
                        job.run_start  = 16'(start_reg);
                        job.run_len    = 16'(len_reg);
                        job.has_op     = is_op;
                        mode_next      = MODE_IDLE;
                    end else begin
                        alive_next     = fed_alive;
                        len_next       = fed_len;
                        digits_next    = fed_digits;
                        job.has_run    = s_is_end;
                        job.run_hit    = hit_fed;
                        job.run_digits = fed_digits;
                        job.run_start  = 16'(start_reg);
                        job.run_len    = 16'(fed_len);
                    end
                end
                MODE_QUOTE: begin
                    len_next       = qlen;
                    job.run_quoted = 1'b1;
                    job.run_start  = 16'(start_reg);
                    job.run_len    = 16'(qlen);
                    if (is_quote && !bslash_reg) begin
                        job.has_run = 1'b1;
                        mode_next   = MODE_IDLE;
                    end else begin
                        bslash_next = is_bslash;
                        job.has_run = s_is_end;
                    end
                end
                default: begin
                    // between tokens; the unused fourth code behaves the same
                    if (is_sp) begin
                        job.has_run = 1'b0;
                    end else if (is_op) begin
                        job.has_op = 1'b1;
                    end else if (is_quote) begin
                        mode_next      = MODE_QUOTE;
                        start_next     = pos_reg;
                        len_next       = POSITION_BITS'(1);
                        bslash_next    = 1'b0;
                        job.has_run    = s_is_end;
                        job.run_quoted = 1'b1;
                        job.run_start  = 16'(pos_reg);
                        job.run_len    = 16'd1;
                    end else begin
                        mode_next      = MODE_PLAIN;
                        start_next     = pos_reg;
                        alive_next     = fed_alive;
                        len_next       = fed_len;
                        digits_next    = fed_digits;
                        job.has_run    = s_is_end;
                        job.run_hit    = hit_fed;
                        job.run_digits = fed_digits;
                        job.run_start  = 16'(pos_reg);
                        job.run_len    = 16'(fed_len);
                    end
                end
            endcase

            // end of query: back to the reset state
            if (s_is_end) begin
                mode_next   = MODE_IDLE;
                bslash_next = 1'b0;
                pos_next    = '0;
                start_next  = '0;
                len_next    = '0;
                alive_next  = '1;
                digits_next = 1'b1;
            end
        end
    end

    assign job_push = accept && (job.has_run || job.has_op);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_IDLE;
            bslash_reg <= 1'b0;
            pos_reg    <= '0;
            start_reg  <= '0;
            len_reg    <= '0;
            alive_reg  <= '1;
            digits_reg <= 1'b1;
        end else begin
            mode_reg   <= mode_next;
            bslash_reg <= bslash_next;
            pos_reg    <= pos_next;
            start_reg  <= start_next;
            len_reg    <= len_next;
            alive_reg  <= alive_next;
            digits_reg <= digits_next;
        end
    end

    `SQT_ASSERT_IMPL(a_open_token_nonempty, aclk, aresetn, mode_reg != MODE_IDLE, len_reg != '0, "open token with zero length")
    `SQT_ASSERT_IMPL(a_start_not_ahead, aclk, aresetn, mode_reg != MODE_IDLE, start_reg <= pos_reg, "token start beyond position")
    `SQT_ASSERT_NEXT(a_end_resets, aclk, aresetn, accept && s_is_end, mode_reg == MODE_IDLE && pos_reg == '0, "query end did not restart scan")

endmodule

FILE: rtl/sqt_fifo.sv
module sqt_fifo (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  sqt_pkg::tok_job_t     push_job,
    input  logic                  pop,
    output sqt_pkg::tok_job_t     head_job,
    output sqt_pkg::fifo_status_t status
);
    import sqt_pkg::*;

    localparam int PTR_W = (JOB_FIFO_DEPTH > 1) ? $clog2(JOB_FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(JOB_FIFO_DEPTH + 1);

    tok_job_t           mem [JOB_FIFO_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_push, do_pop;

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(JOB_FIFO_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign status.full  = (count_reg == CNT_W'(JOB_FIFO_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head_job     = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wrap_inc(wr_ptr_reg);
            end
            if (do_pop) begin
                rd_ptr_reg <= wrap_inc(rd_ptr_reg);
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + CNT_W'(1);
                2'b01:   count_reg <= count_reg - CNT_W'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

FILE: rtl/sqt_back.sv
`include "sql_query_tokenizer_top_macros.svh"

module sqt_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  sqt_pkg::tok_job_t     job,
    input  sqt_pkg::fifo_status_t fifo_status,
    output logic                  pop,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [1:0]            m_token_kind,
    output logic [4:0]            m_keyword_index,
    output logic [1:0]            m_operator_code,
    output logic [15:0]           m_start_pos,
    output logic [15:0]           m_token_len,
    output logic                  m_last_of_run
);
    import sqt_pkg::*;

    logic        m_valid_reg;
    tok_kind_t   kind_reg;
    logic [4:0]  kwi_reg;
    op_code_t    opc_reg;
    logic [15:0] start_reg;
    logic [15:0] len_reg;
    logic        last_reg;

    // operator still owed after a run that it ended
    logic        pend_reg;
    op_code_t    pend_opc_reg;
    logic [15:0] pend_pos_reg;

    logic        out_free;
    logic        kw_found;
    logic [4:0]  kw_idx;
    tok_kind_t   run_kind;
    logic [4:0]  run_kwi;

    // first live keyword wins
    always_comb begin
        kw_found = 1'b0;
        kw_idx   = '0;
        for (int i = KW_COUNT - 1; i >= 0; i--) begin
            if (job.run_hit[i]) begin
                kw_found = 1'b1;
                kw_idx   = 5'(i);
            end
        end
        if (job.run_quoted) begin
            run_kind = KIND_VALUE;
        end else if (kw_found) begin
            run_kind = KIND_KEYWORD;
        end else if (job.run_digits) begin
            run_kind = KIND_VALUE;
        end else begin
            run_kind = KIND_IDENT;
        end
        run_kwi = (!job.run_quoted && kw_found) ? kw_idx : 5'd0;
    end

    assign out_free = !m_valid_reg || m_ready;
    assign pop      = out_free && !pend_reg && !fifo_status.empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            pend_reg    <= 1'b0;
        end else if (out_free) begin
            if (pend_reg) begin
                m_valid_reg <= 1'b1;
                pend_reg    <= 1'b0;
                kind_reg    <= KIND_OPERATOR;
                kwi_reg     <= '0;
                opc_reg     <= pend_opc_reg;
                start_reg   <= pend_pos_reg;
                len_reg     <= 16'd1;
                last_reg    <= 1'b1;
            end else if (!fifo_status.empty) begin
                m_valid_reg <= 1'b1;
                if (job.has_run) begin
                    kind_reg     <= run_kind;
                    kwi_reg      <= run_kwi;
                    opc_reg      <= OP_LPAREN;
                    start_reg    <= job.run_start;
                    len_reg      <= job.run_len;
                    last_reg     <= !job.has_op;
                    pend_reg     <= job.has_op;
                    pend_opc_reg <= job.op_code;
                    pend_pos_reg <= job.op_pos;
                end else begin
                    kind_reg  <= KIND_OPERATOR;
                    kwi_reg   <= '0;
                    opc_reg   <= job.op_code;
                    start_reg <= job.op_pos;
                    len_reg   <= 16'd1;
                    last_reg  <= 1'b1;
                end
            end else begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_token_kind    = kind_reg;
    assign m_keyword_index = kwi_reg;
    assign m_operator_code = opc_reg;
    assign m_start_pos     = start_reg;
    assign m_token_len     = len_reg;
    assign m_last_of_run   = last_reg;

    `SQT_ASSERT_IMPL(a_pend_behind_run, aclk, aresetn, pend_reg, m_valid && !m_last_of_run, "owed operator without a run in front")
    `SQT_ASSERT_NEXT(a_pend_follows, aclk, aresetn, pend_reg && m_ready, m_valid && m_last_of_run && m_token_kind == KIND_OPERATOR, "owed operator not delivered next")
    `SQT_ASSERT_IMPL(a_no_pop_while_pend, aclk, aresetn, pend_reg, !pop, "queue read while an operator is owed")

endmodule

FILE: rtl/sql_query_tokenizer_top.sv
// SQL query tokenizer. Query characters arrive one word per cycle on the s_
// channel (s_is_end marks the last character of a query); token descriptors
// leave on the m_ channel, each giving kind, keyword index, operator code,
// start offset and length, with m_last_of_run set on the final descriptor
// caused by a character. A front stage classifies every character in the
// cycle it is accepted, updating the 20-entry keyword mask, digit flag and
// token bookkeeping in parallel, and hands the result to a four-entry job
// queue; the back stage resolves the keyword priority and drives the output
// register. Input is taken at one character per cycle whenever the queue has
// room. The output register delivers one descriptor per cycle while m_ready
// is high, so a character that ends a run with an operator yields two
// descriptors; the queue soaks these up and sustained throughput stays at
// one character per cycle for ordinary text. A character's descriptors pass
// through a queue entry and then the output register. Positions and lengths
// saturate at 2^POSITION_BITS - 1 and are reported in their low 16 bits.
// After the last character of a query, offsets restart at zero. No clearing
// pass is needed after reset.
module sql_query_tokenizer_top #(
    parameter int POSITION_BITS = sqt_pkg::POSITION_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_ch,
    input  logic        s_is_end,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_token_kind,
    output logic [4:0]  m_keyword_index,
    output logic [1:0]  m_operator_code,
    output logic [15:0] m_start_pos,
    output logic [15:0] m_token_len,
    output logic        m_last_of_run
);
    import sqt_pkg::*;

    // front to queue
    logic         job_push;
    tok_job_t     push_job;
    // queue to back
    logic         job_pop;
    tok_job_t     head_job;
    fifo_status_t fifo_status;

    // scanner: character classes, keyword mask, token bookkeeping
    sqt_front #(
        .POSITION_BITS(POSITION_BITS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_ch        (s_ch),
        .s_is_end    (s_is_end),
        .fifo_status (fifo_status),
        .job_push    (job_push),
        .job         (push_job)
    );

    // decoupling queue; one entry per character that yields descriptors
    sqt_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (job_push),
        .push_job (push_job),
        .pop      (job_pop),
        .head_job (head_job),
        .status   (fifo_status)
    );

    // emitter: keyword priority, kind resolution, output register
    sqt_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .job             (head_job),
        .fifo_status     (fifo_status),
        .pop             (job_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_token_kind    (m_token_kind),
        .m_keyword_index (m_keyword_index),
        .m_operator_code (m_operator_code),
        .m_start_pos     (m_start_pos),
        .m_token_len     (m_token_len),
        .m_last_of_run   (m_last_of_run)
    );

endmodule
